@@ src/strmq_pkg.sv @@
`default_nettype none

package strmq_pkg;

  localparam int unsigned MAX_LENGTH = 1024;
  localparam int unsigned LEVELS     = 11;
  localparam int unsigned POS_W      = 11;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned IDX_W      = $clog2(MAX_LENGTH);
  localparam int unsigned ROW_W      = $clog2(LEVELS);
  localparam int unsigned TAB_DEPTH  = (LEVELS - 1) * MAX_LENGTH;
  localparam int unsigned TAB_AW     = ROW_W + IDX_W;
  localparam int unsigned SPAN_W     = POS_W + 1;

  typedef logic [POS_W-1:0] pos_t;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_BUILD = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  localparam logic KIND_DONE   = 1'b0;
  localparam logic KIND_ANSWER = 1'b1;

  // highest set bit of a nonzero count
  function automatic logic [ROW_W-1:0] floor_log2(input pos_t n);
    logic [ROW_W-1:0] r;
    r = '0;
    for (int i = 0; i < POS_W; i++) begin
      if (n[i]) r = ROW_W'(i);
    end
    return r;
  endfunction

  // pull a range end into [1, lim]
  function automatic pos_t clamp_pos(input pos_t p, input pos_t lim);
    pos_t r;
    r = p;
    if (p == '0) r = pos_t'(1);
    if (r > lim) r = lim;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/strmq_ram.sv @@
`default_nettype none

// one write port, two registered read ports
module strmq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_a_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic      [Width-1:0]         rdata_a_o,
  output logic      [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

@@ src/sparse_table_range_min_index.sv @@
`default_nettype none

// channel   direction  handshake                     beat contents
// command   in         start_i high, busy_o low      command, position, value, range ends
// result    out        result_valid_o, one cycle     kind, min_position
// config    in         length_in_use_we_i            length_in_use
//
// write: stored on accept, block stays idle. query with equal ends, or before any build:
// answer in the cycle after accept. other queries: registered ends, table read, value read,
// compare, set by the registered reads of the table memory and then the value memory.
// build of len = min(length_in_use, 1024) positions: for each level i >= 1 with 2^i <= len,
// (len - 2^i + 1) entries. level 1 entries read the value memory only, higher levels
// read the table memory first; one table write per entry. done beat follows the last write.
// build of fewer than two positions: done beat in the cycle after accept.
// reset: asynchronous, active low; length_in_use returns to 1 and no table is built.
// the memories hold no reset value. the receiver cannot stall: each result beat is
// presented for one cycle only.

module sparse_table_range_min_index (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  output logic                                   busy_o,
  input  wire logic [1:0]                        command_i,
  input  wire logic [strmq_pkg::POS_W-1:0]       position_i,
  input  wire logic signed [strmq_pkg::VAL_W-1:0] value_i,
  input  wire logic [strmq_pkg::POS_W-1:0]       range_first_i,
  input  wire logic [strmq_pkg::POS_W-1:0]       range_last_i,
  input  wire logic                              length_in_use_we_i,
  input  wire logic [strmq_pkg::POS_W-1:0]       length_in_use_i,
  output logic                                   result_valid_o,
  output logic                                   kind_o,
  output logic [strmq_pkg::POS_W-1:0]            min_position_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QPREP,  // query ends registered, pick level
    ST_BREAD,  // build entry: issue reads of the level below
    ST_TAB,    // table data back, issue value reads
    ST_VAL     // value data back, compare and write or answer
  } state_e;

  state_e                          state_q;
  logic                            is_build_q;
  strmq_pkg::pos_t                 len_cfg_q;
  strmq_pkg::pos_t                 built_len_q;
  strmq_pkg::pos_t                 lo_q, hi_q;
  strmq_pkg::pos_t                 pos_l_q, pos_r_q;
  logic [strmq_pkg::ROW_W-1:0]     lvl_q;
  logic [strmq_pkg::IDX_W-1:0]     j0_q;
  logic                            res_valid_q;
  logic                            kind_q;
  strmq_pkg::pos_t                 min_pos_q;

  // memory ports
  logic                            val_we;
  logic [strmq_pkg::IDX_W-1:0]     val_waddr, val_raddr_a, val_raddr_b;
  logic [strmq_pkg::VAL_W-1:0]     val_rd_a, val_rd_b;
  logic                            tab_we;
  logic [strmq_pkg::TAB_AW-1:0]    tab_waddr, tab_raddr_a, tab_raddr_b;
  strmq_pkg::pos_t                 tab_rd_a, tab_rd_b;

  // datapath helpers
  strmq_pkg::cmd_e                 cmd;
  strmq_pkg::pos_t                 ca, cb, q_lo, q_hi, bld_len;
  strmq_pkg::pos_t                 q_n, q_idx_r, lo_m1, pos_m1, half;
  strmq_pkg::pos_t                 dir_l, dir_r, sel_l, sel_r, sel_l_m1, sel_r_m1, pick;
  logic [strmq_pkg::ROW_W-1:0]     q_k, row;
  logic [strmq_pkg::IDX_W-1:0]     idx_a, idx_b;
  logic [strmq_pkg::SPAN_W-1:0]    span, span_next, j_next;
  logic                            use_direct, cont_lvl, cont_next, accept;

  assign accept = start_i && (state_q == ST_IDLE);
  assign cmd    = strmq_pkg::cmd_e'(command_i);
  assign busy_o = (state_q != ST_IDLE);

  always_comb begin
    // query ends clamped to the built range, then ordered
    ca   = strmq_pkg::clamp_pos(range_first_i, built_len_q);
    cb   = strmq_pkg::clamp_pos(range_last_i, built_len_q);
    q_lo = (ca < cb) ? ca : cb;
    q_hi = (ca < cb) ? cb : ca;

    bld_len = (len_cfg_q > strmq_pkg::POS_W'(strmq_pkg::MAX_LENGTH))
            ? strmq_pkg::POS_W'(strmq_pkg::MAX_LENGTH) : len_cfg_q;

    // two overlapping power-of-two blocks
    q_n = hi_q - lo_q + strmq_pkg::pos_t'(1);
    q_k = strmq_pkg::floor_log2(q_n);
    if (q_k > strmq_pkg::ROW_W'(strmq_pkg::LEVELS - 1)) begin
      q_k = strmq_pkg::ROW_W'(strmq_pkg::LEVELS - 1);
    end
    q_idx_r = hi_q - (strmq_pkg::pos_t'(1) << q_k);
    lo_m1   = lo_q - strmq_pkg::pos_t'(1);

    // build loop bounds
    half      = strmq_pkg::pos_t'(1) << (lvl_q - strmq_pkg::ROW_W'(1));
    span      = strmq_pkg::SPAN_W'(1) << lvl_q;
    span_next = span << 1;
    j_next    = strmq_pkg::SPAN_W'(j0_q) + strmq_pkg::SPAN_W'(1);
    cont_lvl  = (j_next + span) <= strmq_pkg::SPAN_W'(built_len_q);
    cont_next = (lvl_q < strmq_pkg::ROW_W'(strmq_pkg::LEVELS - 1))
             && (span_next <= strmq_pkg::SPAN_W'(built_len_q));

    // level 0 is the identity, so its positions need no table read
    if (state_q == ST_QPREP) begin
      row        = q_k - strmq_pkg::ROW_W'(1);
      idx_a      = lo_m1[strmq_pkg::IDX_W-1:0];
      idx_b      = q_idx_r[strmq_pkg::IDX_W-1:0];
      dir_l      = lo_q;
      dir_r      = hi_q;
      use_direct = (q_k == '0);
    end else begin
      row        = lvl_q - strmq_pkg::ROW_W'(2);
      idx_a      = j0_q;
      idx_b      = j0_q + half[strmq_pkg::IDX_W-1:0];
      dir_l      = strmq_pkg::pos_t'(j0_q) + strmq_pkg::pos_t'(1);
      dir_r      = strmq_pkg::pos_t'(j0_q) + strmq_pkg::pos_t'(2);
      use_direct = (lvl_q == strmq_pkg::ROW_W'(1));
    end
    tab_raddr_a = {row, idx_a};
    tab_raddr_b = {row, idx_b};

    sel_l    = (state_q == ST_TAB) ? tab_rd_a : dir_l;
    sel_r    = (state_q == ST_TAB) ? tab_rd_b : dir_r;
    sel_l_m1 = sel_l - strmq_pkg::pos_t'(1);
    sel_r_m1 = sel_r - strmq_pkg::pos_t'(1);
    val_raddr_a = sel_l_m1[strmq_pkg::IDX_W-1:0];
    val_raddr_b = sel_r_m1[strmq_pkg::IDX_W-1:0];

    // right side wins only when strictly smaller: leftmost minimum
    pick = ($signed(val_rd_b) < $signed(val_rd_a)) ? pos_r_q : pos_l_q;

    // value store write, positions outside 1..MAX_LENGTH dropped
    pos_m1    = position_i - strmq_pkg::pos_t'(1);
    val_we    = accept && (cmd == strmq_pkg::CMD_WRITE) && (position_i != '0)
             && (position_i <= strmq_pkg::POS_W'(strmq_pkg::MAX_LENGTH));
    val_waddr = pos_m1[strmq_pkg::IDX_W-1:0];

    tab_we    = (state_q == ST_VAL) && is_build_q;
    tab_waddr = {lvl_q - strmq_pkg::ROW_W'(1), j0_q};
  end

  strmq_ram #(
    .Width (strmq_pkg::VAL_W),
    .Depth (strmq_pkg::MAX_LENGTH)
  ) u_values (
    .clk_i     (clk_i),
    .we_i      (val_we),
    .waddr_i   (val_waddr),
    .wdata_i   (value_i),
    .raddr_a_i (val_raddr_a),
    .raddr_b_i (val_raddr_b),
    .rdata_a_o (val_rd_a),
    .rdata_b_o (val_rd_b)
  );

  // levels 1 and up; row r holds level r+1
  strmq_ram #(
    .Width (strmq_pkg::POS_W),
    .Depth (strmq_pkg::TAB_DEPTH)
  ) u_levels (
    .clk_i     (clk_i),
    .we_i      (tab_we),
    .waddr_i   (tab_waddr),
    .wdata_i   (pick),
    .raddr_a_i (tab_raddr_a),
    .raddr_b_i (tab_raddr_b),
    .rdata_a_o (tab_rd_a),
    .rdata_b_o (tab_rd_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      is_build_q  <= 1'b0;
      len_cfg_q   <= strmq_pkg::pos_t'(1);
      built_len_q <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      pos_l_q     <= '0;
      pos_r_q     <= '0;
      lvl_q       <= '0;
      j0_q        <= '0;
      res_valid_q <= 1'b0;
      kind_q      <= strmq_pkg::KIND_DONE;
      min_pos_q   <= '0;
    end else begin
      res_valid_q <= 1'b0;
      if (length_in_use_we_i) len_cfg_q <= length_in_use_i;
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            case (cmd)
              strmq_pkg::CMD_BUILD: begin
                built_len_q <= bld_len;
                if (bld_len < strmq_pkg::pos_t'(2)) begin
                  // nothing above level 0 to fill
                  res_valid_q <= 1'b1;
                  kind_q      <= strmq_pkg::KIND_DONE;
                  min_pos_q   <= '0;
                end else begin
                  is_build_q <= 1'b1;
                  lvl_q      <= strmq_pkg::ROW_W'(1);
                  j0_q       <= '0;
                  state_q    <= ST_BREAD;
                end
              end
              strmq_pkg::CMD_QUERY: begin
                if (built_len_q == '0) begin
                  res_valid_q <= 1'b1;
                  kind_q      <= strmq_pkg::KIND_ANSWER;
                  min_pos_q   <= '0;
                end else if (ca == cb) begin
                  res_valid_q <= 1'b1;
                  kind_q      <= strmq_pkg::KIND_ANSWER;
                  min_pos_q   <= ca;
                end else begin
                  is_build_q <= 1'b0;
                  lo_q       <= q_lo;
                  hi_q       <= q_hi;
                  state_q    <= ST_QPREP;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_QPREP, ST_BREAD: begin
          pos_l_q <= dir_l;
          pos_r_q <= dir_r;
          state_q <= use_direct ? ST_VAL : ST_TAB;
        end
        ST_TAB: begin
          pos_l_q <= tab_rd_a;
          pos_r_q <= tab_rd_b;
          state_q <= ST_VAL;
        end
        ST_VAL: begin
          if (is_build_q) begin
            if (cont_lvl) begin
              j0_q    <= j_next[strmq_pkg::IDX_W-1:0];
              state_q <= ST_BREAD;
            end else if (cont_next) begin
              lvl_q   <= lvl_q + strmq_pkg::ROW_W'(1);
              j0_q    <= '0;
              state_q <= ST_BREAD;
            end else begin
              res_valid_q <= 1'b1;
              kind_q      <= strmq_pkg::KIND_DONE;
              min_pos_q   <= '0;
              state_q     <= ST_IDLE;
            end
          end else begin
            res_valid_q <= 1'b1;
            kind_q      <= strmq_pkg::KIND_ANSWER;
            min_pos_q   <= pick;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign result_valid_o = res_valid_q;
  assign kind_o         = kind_q;
  assign min_position_o = min_pos_q;

`ifndef SYNTHESIS
  // a result beat only shows once the block is free again
  a_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o)
    else $error("result beat while busy");

  // answers stay inside the built range
  a_answer_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (kind_o == strmq_pkg::KIND_ANSWER)) |-> (min_position_o <= built_len_q))
    else $error("query answer outside built range");

  // done beats carry no position
  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (kind_o == strmq_pkg::KIND_DONE)) |-> (min_position_o == '0))
    else $error("build done beat with nonzero position");

  // table writes never leave the span that the build covers
  a_table_write_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tab_we |-> ((strmq_pkg::SPAN_W'(j0_q) + span) <= strmq_pkg::SPAN_W'(built_len_q)))
    else $error("table write beyond built length");
`endif

endmodule

`default_nettype wire
